// File: rtl/partial_register_file_alu_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the partial register file ALU
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PARTIAL_REGISTER_FILE_ALU_MACROS_SVH
`define PARTIAL_REGISTER_FILE_ALU_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising clock edge, disabled while reset is asserted.
`define PRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check prop on every rising clock edge, reset included.
`define PRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRF_ASSERT(lbl, clk, rstn, prop, msg)
`define PRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// Shared codes, widths and types of the partial register file ALU.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ActW  = 3;
  localparam int unsigned CodeW = 4;

  // Actions
  localparam logic [ActW-1:0] ACT_SHOW = 3'd1;
  localparam logic [ActW-1:0] ACT_MOV  = 3'd2;
  localparam logic [ActW-1:0] ACT_ADD  = 3'd3;
  localparam logic [ActW-1:0] ACT_SUB  = 3'd4;

  // Register view codes
  localparam logic [CodeW-1:0] CODE_EAX = 4'd0;
  localparam logic [CodeW-1:0] CODE_ECX = 4'd1;
  localparam logic [CodeW-1:0] CODE_EDX = 4'd2;
  localparam logic [CodeW-1:0] CODE_AX  = 4'd3;
  localparam logic [CodeW-1:0] CODE_CX  = 4'd4;
  localparam logic [CodeW-1:0] CODE_DX  = 4'd5;
  localparam logic [CodeW-1:0] CODE_AL  = 4'd6;
  localparam logic [CodeW-1:0] CODE_AH  = 4'd7;
  localparam logic [CodeW-1:0] CODE_CL  = 4'd8;
  localparam logic [CodeW-1:0] CODE_CH  = 4'd9;
  localparam logic [CodeW-1:0] CODE_DL  = 4'd10;
  localparam logic [CodeW-1:0] CODE_DH  = 4'd11;
  localparam logic [CodeW-1:0] CODE_EIP = 4'd12;

  // Register file write request
  typedef struct packed {
    logic              en;
    logic [CodeW-1:0]  code;
    logic [DataW-1:0]  value;
  } wr_req_t;

  // Register file read result
  typedef struct packed {
    logic              ok;
    logic [DataW-1:0]  value;
  } rd_view_t;

endpackage

// File: rtl/prf_regfile.sv
// ----------------------------------------------------------------------------
// prf_regfile
// EAX/ECX/EDX with partial views, plus the instruction counter.
// ----------------------------------------------------------------------------
module prf_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  prf_pkg::wr_req_t              wr_i,
  input  logic [prf_pkg::CodeW-1:0]     src_code_i,
  input  logic [prf_pkg::CodeW-1:0]     dst_code_i,
  output prf_pkg::rd_view_t             src_view_o,
  output prf_pkg::rd_view_t             dst_view_o
);

  `include "partial_register_file_alu_macros.svh"

  logic [prf_pkg::DataW-1:0] reg_a_q, reg_a_d;
  logic [prf_pkg::DataW-1:0] reg_c_q, reg_c_d;
  logic [prf_pkg::DataW-1:0] reg_d_q, reg_d_d;
  logic [prf_pkg::DataW-1:0] count_q, count_d;
  logic [prf_pkg::DataW-1:0] count_inc;

  // Counter as seen by this step, i.e. after its own increment
  assign count_inc = count_q + 32'd1;

  function automatic prf_pkg::rd_view_t read_view(
    input logic [prf_pkg::CodeW-1:0] code,
    input logic [prf_pkg::DataW-1:0] a,
    input logic [prf_pkg::DataW-1:0] c,
    input logic [prf_pkg::DataW-1:0] d,
    input logic [prf_pkg::DataW-1:0] cnt
  );
    prf_pkg::rd_view_t r;
    r.ok    = 1'b1;
    r.value = '0;
    case (code)
      prf_pkg::CODE_EAX: r.value = a;
      prf_pkg::CODE_ECX: r.value = c;
      prf_pkg::CODE_EDX: r.value = d;
      prf_pkg::CODE_AX:  r.value = {16'd0, a[15:0]};
      prf_pkg::CODE_CX:  r.value = {16'd0, c[15:0]};
      prf_pkg::CODE_DX:  r.value = {16'd0, d[15:0]};
      prf_pkg::CODE_AL:  r.value = {24'd0, a[7:0]};
      prf_pkg::CODE_AH:  r.value = {24'd0, a[15:8]};
      prf_pkg::CODE_CL:  r.value = {24'd0, c[7:0]};
      prf_pkg::CODE_CH:  r.value = {24'd0, c[15:8]};
      prf_pkg::CODE_DL:  r.value = {24'd0, d[7:0]};
      prf_pkg::CODE_DH:  r.value = {24'd0, d[15:8]};
      prf_pkg::CODE_EIP: r.value = cnt;
      default:           r.ok    = 1'b0;
    endcase
    return r;
  endfunction

  assign src_view_o = read_view(src_code_i, reg_a_q, reg_c_q, reg_d_q, count_inc);
  assign dst_view_o = read_view(dst_code_i, reg_a_q, reg_c_q, reg_d_q, count_inc);

  // Merge the write into the addressed part only
  always_comb begin
    reg_a_d = reg_a_q;
    reg_c_d = reg_c_q;
    reg_d_d = reg_d_q;
    count_d = step_i ? count_inc : count_q;
    if (wr_i.en) begin
      case (wr_i.code)
        prf_pkg::CODE_EAX: reg_a_d = wr_i.value;
        prf_pkg::CODE_ECX: reg_c_d = wr_i.value;
        prf_pkg::CODE_EDX: reg_d_d = wr_i.value;
        prf_pkg::CODE_AX:  reg_a_d[15:0] = wr_i.value[15:0];
        prf_pkg::CODE_CX:  reg_c_d[15:0] = wr_i.value[15:0];
        prf_pkg::CODE_DX:  reg_d_d[15:0] = wr_i.value[15:0];
        prf_pkg::CODE_AL:  reg_a_d[7:0]  = wr_i.value[7:0];
        prf_pkg::CODE_AH:  reg_a_d[15:8] = wr_i.value[7:0];
        prf_pkg::CODE_CL:  reg_c_d[7:0]  = wr_i.value[7:0];
        prf_pkg::CODE_CH:  reg_c_d[15:8] = wr_i.value[7:0];
        prf_pkg::CODE_DL:  reg_d_d[7:0]  = wr_i.value[7:0];
        prf_pkg::CODE_DH:  reg_d_d[15:8] = wr_i.value[7:0];
        default: begin
          // counter and invalid codes are never written
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_a_q <= '0;
      reg_c_q <= '0;
      reg_d_q <= '0;
      count_q <= '0;
    end else begin
      reg_a_q <= reg_a_d;
      reg_c_q <= reg_c_d;
      reg_d_q <= reg_d_d;
      count_q <= count_d;
    end
  end

  `PRF_ASSERT(a_count_step, clk_i, rst_ni, step_i |=> count_q == $past(count_q) + 32'd1, "counter did not advance on a step")
  `PRF_ASSERT(a_count_hold, clk_i, rst_ni, !step_i |=> $stable(count_q), "counter moved without a step")
  `PRF_ASSERT(a_al_merge, clk_i, rst_ni, (wr_i.en && wr_i.code == prf_pkg::CODE_AL) |=> reg_a_q[31:8] == $past(reg_a_q[31:8]), "AL write disturbed upper EAX bits")

endmodule

// File: rtl/prf_alu.sv
// ----------------------------------------------------------------------------
// prf_alu
// Decode one instruction, form the write request and the show word.
// ----------------------------------------------------------------------------
module prf_alu (
  input  logic [prf_pkg::ActW-1:0]   action_i,
  input  logic [prf_pkg::CodeW-1:0]  dest_code_i,
  input  logic                       source_is_immediate_i,
  input  logic [prf_pkg::CodeW-1:0]  source_code_i,
  input  logic [prf_pkg::DataW-1:0]  immediate_i,
  input  prf_pkg::rd_view_t          src_view_i,
  input  prf_pkg::rd_view_t          dst_view_i,
  output prf_pkg::wr_req_t           wr_o,
  output logic                       show_valid_o,
  output logic [prf_pkg::DataW-1:0]  show_value_o
);

  logic                      is_arith;
  logic                      dst_writable;
  logic                      src_ok;
  logic [prf_pkg::DataW-1:0] src_val;

  assign src_val = source_is_immediate_i ? immediate_i : src_view_i.value;

  assign is_arith = (action_i == prf_pkg::ACT_MOV) || (action_i == prf_pkg::ACT_ADD) ||
                    (action_i == prf_pkg::ACT_SUB);

  // Counter and invalid codes: neither writable nor usable as a source
  assign dst_writable = dst_view_i.ok && (dest_code_i != prf_pkg::CODE_EIP);
  assign src_ok       = source_is_immediate_i ||
                        (src_view_i.ok && (source_code_i != prf_pkg::CODE_EIP));

  always_comb begin
    wr_o.en   = is_arith && dst_writable && src_ok;
    wr_o.code = dest_code_i;
    case (action_i)
      prf_pkg::ACT_ADD: wr_o.value = dst_view_i.value + src_val;
      prf_pkg::ACT_SUB: wr_o.value = dst_view_i.value - src_val;
      default:          wr_o.value = src_val;
    endcase
  end

  assign show_valid_o = (action_i == prf_pkg::ACT_SHOW) &&
                        (source_is_immediate_i || src_view_i.ok);
  assign show_value_o = src_val;

endmodule

// File: rtl/partial_register_file_alu.sv
// ----------------------------------------------------------------------------
// partial_register_file_alu
// One decoded instruction per word against EAX/ECX/EDX and a counter.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | action, codes, flag, immediate
//  out     | output    | out_valid_o / out_stall_i| shown_value_o
//
//  One word per cycle is taken while in_stall_o is low. A word executes in the
//  input register: the register file is read, the add/sub done and the write
//  merged at the next edge, so the following word sees the updated state.
//  A show word then moves into the output register, which drives out_valid_o,
//  once that register is free.
//  Reset clears the registers, the counter and both valid flags.
//  in_stall_o rises only while a show word waits behind a stalled output word.
// ----------------------------------------------------------------------------
module partial_register_file_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [prf_pkg::ActW-1:0]   action_i,
  input  logic [prf_pkg::CodeW-1:0]  dest_code_i,
  input  logic                       source_is_immediate_i,
  input  logic [prf_pkg::CodeW-1:0]  source_code_i,
  input  logic [prf_pkg::DataW-1:0]  immediate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [prf_pkg::DataW-1:0]  shown_value_o
);

  `include "partial_register_file_alu_macros.svh"

  // Input register
  logic                      s1_valid_q;
  logic [prf_pkg::ActW-1:0]  s1_action_q;
  logic [prf_pkg::CodeW-1:0] s1_dest_q;
  logic                      s1_imm_sel_q;
  logic [prf_pkg::CodeW-1:0] s1_src_q;
  logic [prf_pkg::DataW-1:0] s1_imm_q;

  // Result register
  logic                      out_valid_q;
  logic [prf_pkg::DataW-1:0] out_value_q;

  prf_pkg::rd_view_t         src_view;
  prf_pkg::rd_view_t         dst_view;
  prf_pkg::wr_req_t          wr_req;
  prf_pkg::wr_req_t          wr_gated;
  logic                      show_valid;
  logic [prf_pkg::DataW-1:0] show_value;

  logic exec_go;
  logic in_take;
  logic out_free;

  // The output slot frees up this cycle if empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  // Execute unless a show word would overrun a held output word
  assign exec_go  = s1_valid_q && (out_free || !show_valid);
  // Stall the input only while the input register is full and stuck
  assign in_stall_o = s1_valid_q && !exec_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || exec_go) begin
      s1_valid_q <= in_take;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q  <= action_i;
      s1_dest_q    <= dest_code_i;
      s1_imm_sel_q <= source_is_immediate_i;
      s1_src_q     <= source_code_i;
      s1_imm_q     <= immediate_i;
    end
  end

  prf_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (exec_go),
    .wr_i       (wr_gated),
    .src_code_i (s1_src_q),
    .dst_code_i (s1_dest_q),
    .src_view_o (src_view),
    .dst_view_o (dst_view)
  );

  prf_alu u_alu (
    .action_i              (s1_action_q),
    .dest_code_i           (s1_dest_q),
    .source_is_immediate_i (s1_imm_sel_q),
    .source_code_i         (s1_src_q),
    .immediate_i           (s1_imm_q),
    .src_view_i            (src_view),
    .dst_view_i            (dst_view),
    .wr_o                  (wr_req),
    .show_valid_o          (show_valid),
    .show_value_o          (show_value)
  );

  // Gate the write with the execute strobe
  always_comb begin
    wr_gated    = wr_req;
    wr_gated.en = wr_req.en && exec_go;
  end

  // Result register: drop a taken word, load a new show word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go && show_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && show_valid) begin
      out_value_q <= show_value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shown_value_o = out_value_q;

  `PRF_ASSERT_ALWAYS(a_stall_needs_word, clk_i, in_stall_o |-> s1_valid_q, "input stalled with empty input register")
  `PRF_ASSERT(a_s1_hold, clk_i, rst_ni, (s1_valid_q && !exec_go) |=> s1_valid_q && $stable(s1_imm_q) && $stable(s1_action_q), "stuck input word changed")
  `PRF_ASSERT(a_no_overrun, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> $stable(out_value_q), "held output word overwritten")

endmodule
